// ===== hw/rtl/yuv_plane_histogram_stats_assert.svh =====
// Assertion macros for the plane histogram statistics block.
`ifndef YUV_PLANE_HISTOGRAM_STATS_ASSERT_SVH
`define YUV_PLANE_HISTOGRAM_STATS_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define YPH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define YPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/yph_pkg.sv =====
// ----------------------------------------------------------------------------
// yph_pkg
// Shared types and constants of the plane histogram statistics block.
// ----------------------------------------------------------------------------
package yph_pkg;

    localparam int SUM_BITS = 40;
    localparam int BIN_BITS = 17;

    // Configuration register indexes.
    localparam logic [2:0] REG_SAMPLE_BITS = 3'd0;
    localparam logic [2:0] REG_LUMA_LOW    = 3'd1;
    localparam logic [2:0] REG_LUMA_HIGH   = 3'd2;
    localparam logic [2:0] REG_CHROMA_LOW  = 3'd3;
    localparam logic [2:0] REG_CHROMA_HIGH = 3'd4;

    // Plane codes.
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accumulate;  // take the input sample
        logic       clear;       // clear one bin per plane at i_addr, and all sums and masks
        logic       walk_start;  // reset per-plane walk state
        logic       walk_read;   // issue read of walk bin
        logic       walk_eval;   // evaluate returned bin
        logic       emit;        // load the output register
        logic [1:0] plane;       // plane for walk / emit
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;  // output register holds an untaken result
    } t_status;

endpackage

// ===== hw/rtl/yph_ram.sv =====
// ----------------------------------------------------------------------------
// yph_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module yph_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/yph_datapath.sv =====
// ----------------------------------------------------------------------------
// yph_datapath
// Histogram memories, per-plane sums, the bin walk and the output register.
// ----------------------------------------------------------------------------
module yph_datapath #(
    parameter int MAX_SAMPLE_BITS = 10,
    parameter int COUNT_BITS      = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  yph_pkg::t_cmd              i_cmd,
    output yph_pkg::t_status           o_status,
    input  logic [MAX_SAMPLE_BITS-1:0] i_addr,
    input  logic [MAX_SAMPLE_BITS-1:0] i_top,
    input  logic [COUNT_BITS-1:0]      i_lo_t_y,
    input  logic [COUNT_BITS-1:0]      i_hi_t_y,
    input  logic [COUNT_BITS-1:0]      i_lo_t_c,
    input  logic [COUNT_BITS-1:0]      i_hi_t_c,
    input  logic [1:0]                 i_plane,
    input  logic [15:0]                i_sample_value,
    input  logic [15:0]                i_previous_value,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic [1:0]                 o_stat_plane,
    output logic signed [16:0]         o_min_bin,
    output logic signed [16:0]         o_low_bin,
    output logic signed [16:0]         o_high_bin,
    output logic signed [16:0]         o_max_bin,
    output logic [39:0]                o_value_total,
    output logic [39:0]                o_difference_total,
    output logic [4:0]                 o_bits_used,
    output logic                       o_last_result
);

    localparam int AW = MAX_SAMPLE_BITS;
    localparam int SW = yph_pkg::SUM_BITS;
    localparam int BW = yph_pkg::BIN_BITS;
    localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [BW-1:0] NEG1 = {BW{1'b1}};

    // Sample pipeline: the bin is found at intake, read in stage 1 and
    // written back in stage 2.
    logic              r_s1_v;
    logic [1:0]        r_s1_p;
    logic [AW-1:0]     r_s1_bin;
    logic              r_s2_v;
    logic [1:0]        r_s2_p;
    logic [AW-1:0]     r_s2_bin;

    logic [AW-1:0]     bin_c;
    logic [15:0]       diff_c;
    always_comb begin
        if (i_sample_value > {{(16-AW){1'b0}}, i_top}) begin
            bin_c = i_top;
        end else begin
            bin_c = i_sample_value[AW-1:0];
        end
        diff_c = (i_sample_value > i_previous_value) ?
                 (i_sample_value - i_previous_value) : (i_previous_value - i_sample_value);
    end

    // Per-plane sums and masks.
    logic [SW-1:0] r_vsum [3];
    logic [SW-1:0] r_dsum [3];
    logic [15:0]   r_mask [3];

    // Memory ports.
    logic [COUNT_BITS-1:0] rdata [3];
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [2:0]            we;

    // Forwarding of a bin written in the previous cycle.
    logic                  r_fw_v;
    logic [1:0]            r_fw_p;
    logic [AW-1:0]         r_fw_bin;
    logic [COUNT_BITS-1:0] r_fw_val;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [1:0]            rd_plane;

    assign raddr = (i_cmd.walk_read) ? i_addr : r_s1_bin;

    always_comb begin
        rd_plane = r_s2_p;
        cur_cnt  = rdata[rd_plane];
        if (r_fw_v && r_fw_p == r_s2_p && r_fw_bin == r_s2_bin) begin
            cur_cnt = r_fw_val;
        end
        we    = 3'b000;
        waddr = r_s2_bin;
        wdata = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
        if (i_cmd.clear) begin
            we    = 3'b111;
            waddr = i_addr;
            wdata = '0;
        end else if (r_s2_v) begin
            we[r_s2_p] = 1'b1;
        end
    end

    // Histogram memories, one per plane.
    for (genvar g = 0; g < 3; g++) begin : g_hist
        yph_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << AW)) u_ram (
            .i_clk  (i_clk),
            .i_we   (we[g]),
            .i_waddr(waddr),
            .i_wdata(wdata),
            .i_raddr(raddr),
            .o_rdata(rdata[g])
        );
    end

    // Walk state.
    logic [AW-1:0]        r_wbin_d;    // bin whose data arrives now
    logic                 r_wvalid;
    logic [COUNT_BITS:0]  r_acc;
    logic [BW-1:0]        r_mn, r_mx, r_lo, r_hi;
    logic [COUNT_BITS:0]  acc_n;
    logic [COUNT_BITS-1:0] lo_t, hi_t, wcnt;

    assign lo_t = (i_cmd.plane == yph_pkg::PLANE_Y) ? i_lo_t_y : i_lo_t_c;
    assign hi_t = (i_cmd.plane == yph_pkg::PLANE_Y) ? i_lo_t_y ^ i_lo_t_y ^ i_hi_t_y : i_hi_t_c;
    assign wcnt = rdata[i_cmd.plane];
    assign acc_n = r_acc + {1'b0, wcnt};

    // Pipeline, sums and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_fw_v <= 1'b0;
            r_wvalid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_vsum[k] <= '0;
                r_dsum[k] <= '0;
                r_mask[k] <= '0;
            end
        end else begin
            r_s1_v <= i_cmd.accumulate && (i_plane != 2'd3);
            r_s2_v <= r_s1_v;
            r_fw_v <= r_s2_v && !i_cmd.clear;
            r_wvalid <= i_cmd.walk_read;
            if (i_cmd.accumulate && i_plane != 2'd3) begin
                r_vsum[i_plane] <= ({1'b0, r_vsum[i_plane]} + {{(SW-AW+1){1'b0}}, bin_c}
                                    > {1'b0, SUM_MAX}) ? SUM_MAX :
                                   r_vsum[i_plane] + {{(SW-AW){1'b0}}, bin_c};
                r_dsum[i_plane] <= ({1'b0, r_dsum[i_plane]} + {25'd0, diff_c}
                                    > {1'b0, SUM_MAX}) ? SUM_MAX :
                                   r_dsum[i_plane] + {24'd0, diff_c};
                r_mask[i_plane] <= r_mask[i_plane] | i_sample_value;
            end
            if (i_cmd.clear) begin
                for (int k = 0; k < 3; k++) begin
                    r_vsum[k] <= '0;
                    r_dsum[k] <= '0;
                    r_mask[k] <= '0;
                end
            end
        end
        r_s1_p   <= i_plane;
        r_s1_bin <= bin_c;
        r_s2_p   <= r_s1_p;
        r_s2_bin <= r_s1_bin;
        r_fw_p   <= r_s2_p;
        r_fw_bin <= r_s2_bin;
        r_fw_val <= wdata;
        r_wbin_d <= i_addr;
        if (i_cmd.walk_start) begin
            r_acc <= '0;
            r_mn  <= NEG1;
            r_mx  <= NEG1;
            r_lo  <= NEG1;
            r_hi  <= NEG1;
        end else if (i_cmd.walk_eval && r_wvalid) begin
            r_acc <= acc_n;
            if (wcnt != '0) begin
                if (r_mn == NEG1) r_mn <= {{(BW-AW){1'b0}}, r_wbin_d};
                r_mx <= {{(BW-AW){1'b0}}, r_wbin_d};
            end
            if (r_lo == NEG1 && acc_n >= {1'b0, lo_t}) r_lo <= {{(BW-AW){1'b0}}, r_wbin_d};
            if (r_hi == NEG1 && acc_n >= {1'b0, hi_t}) r_hi <= {{(BW-AW){1'b0}}, r_wbin_d};
        end
    end

    // Output register.
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_stat_plane       <= i_cmd.plane;
            o_min_bin          <= r_mn;
            o_low_bin          <= r_lo;
            o_high_bin         <= r_hi;
            o_max_bin          <= r_mx;
            o_value_total      <= r_vsum[i_cmd.plane];
            o_difference_total <= r_dsum[i_cmd.plane];
            o_bits_used        <= 5'($countones(r_mask[i_cmd.plane]));
            o_last_result      <= (i_cmd.plane == yph_pkg::PLANE_V);
        end
    end

    assign o_out_valid       = r_ov;
    assign o_status.out_busy = r_ov;

endmodule

// ===== hw/rtl/yph_ctrl.sv =====
// ----------------------------------------------------------------------------
// yph_ctrl
// Sequencer for sample intake, end-of-frame bin walk, emit and clearing.
// ----------------------------------------------------------------------------
module yph_ctrl #(
    parameter int MAX_SAMPLE_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_last,
    input  logic [MAX_SAMPLE_BITS-1:0] i_top,
    input  yph_pkg::t_status           i_status,
    output logic                       o_stall,
    output yph_pkg::t_cmd              o_cmd,
    output logic [MAX_SAMPLE_BITS-1:0] o_addr
);

    localparam int AW = MAX_SAMPLE_BITS;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_RUN   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_WALK  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [AW:0]   r_cnt, n_cnt;
    logic [1:0]    r_plane, n_plane;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_plane = r_plane;
        o_cmd   = '0;
        o_cmd.plane = r_plane;
        o_stall = 1'b1;
        o_addr  = r_cnt[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[AW-1:0] == {AW{1'b1}}) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                o_stall = 1'b0;
                o_cmd.accumulate = i_valid;
                if (i_valid && i_last) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end
            end
            S_DRAIN: begin
                // Let the last read-modify-write settle.
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[1:0] == 2'd2) begin
                    n_state = S_WALK;
                    n_cnt   = '0;
                    n_plane = yph_pkg::PLANE_Y;
                    o_cmd.walk_start = 1'b1;
                end
            end
            S_WALK: begin
                o_cmd.walk_eval = 1'b1;
                if (r_cnt <= {1'b0, i_top}) begin
                    o_cmd.walk_read = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                o_cmd.walk_start = 1'b1;
                n_cnt = '0;
                if (r_plane == yph_pkg::PLANE_V) begin
                    n_state = S_CLEAR;
                end else begin
                    n_plane = r_plane + 1'b1;
                    n_state = S_WALK;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_plane <= yph_pkg::PLANE_Y;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_plane <= n_plane;
        end
    end

endmodule

// ===== hw/rtl/yuv_plane_histogram_stats.sv =====
// ----------------------------------------------------------------------------
// yuv_plane_histogram_stats
// Per-plane histogram, sums and percentile statistics of a YUV frame.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while the block is in its run phase. After
// the request marked last_in_frame, the block drains, then walks bins 0 to
// 2^bits-1 of each plane's histogram memory (one read port per plane) and
// emits one result per plane, Y then U then V. It then clears the
// 2^MAX_SAMPLE_BITS histogram entries, one per cycle, before taking the
// next sample; the same clearing pass runs after reset.
module yuv_plane_histogram_stats #(
    parameter int MAX_SAMPLE_BITS = 10,
    parameter int COUNT_BITS      = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [COUNT_BITS-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_plane,
    input  logic [15:0]           i_sample_value,
    input  logic [15:0]           i_previous_value,
    input  logic                  i_last_in_frame,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_stat_plane,
    output logic signed [16:0]    o_min_bin,
    output logic signed [16:0]    o_low_bin,
    output logic signed [16:0]    o_high_bin,
    output logic signed [16:0]    o_max_bin,
    output logic [39:0]           o_value_total,
    output logic [39:0]           o_difference_total,
    output logic [4:0]            o_bits_used,
    output logic                  o_last_result
);

    localparam int AW = MAX_SAMPLE_BITS;

    // Configuration registers.
    logic [4:0]            r_bits;
    logic [COUNT_BITS-1:0] r_lo_y, r_hi_y, r_lo_c, r_hi_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 5'd8;
            r_lo_y <= '0;
            r_hi_y <= '0;
            r_lo_c <= '0;
            r_hi_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                yph_pkg::REG_SAMPLE_BITS: r_bits <= i_cfg_data[4:0];
                yph_pkg::REG_LUMA_LOW:    r_lo_y <= i_cfg_data;
                yph_pkg::REG_LUMA_HIGH:   r_hi_y <= i_cfg_data;
                yph_pkg::REG_CHROMA_LOW:  r_lo_c <= i_cfg_data;
                yph_pkg::REG_CHROMA_HIGH: r_hi_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Top bin from the saturated bit count.
    logic [4:0]    eff_bits;
    logic [AW-1:0] top;
    always_comb begin
        eff_bits = r_bits;
        if (eff_bits < 5'd8) eff_bits = 5'd8;
        if (eff_bits > 5'(AW)) eff_bits = 5'(AW);
        top = AW'(({{AW{1'b0}}, 1'b1} << eff_bits) - 1'b1);
    end

    yph_pkg::t_cmd    cmd;
    yph_pkg::t_status status;
    logic [AW-1:0]    addr;

    yph_ctrl #(.MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last_in_frame),
        .i_top   (top),
        .i_status(status),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .o_addr  (addr)
    );

    yph_datapath #(.MAX_SAMPLE_BITS(MAX_SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_addr            (addr),
        .i_top             (top),
        .i_lo_t_y          (r_lo_y),
        .i_hi_t_y          (r_hi_y),
        .i_lo_t_c          (r_lo_c),
        .i_hi_t_c          (r_hi_c),
        .i_plane           (i_plane),
        .i_sample_value    (i_sample_value),
        .i_previous_value  (i_previous_value),
        .i_out_stall       (i_stall),
        .o_out_valid       (o_valid),
        .o_stat_plane      (o_stat_plane),
        .o_min_bin         (o_min_bin),
        .o_low_bin         (o_low_bin),
        .o_high_bin        (o_high_bin),
        .o_max_bin         (o_max_bin),
        .o_value_total     (o_value_total),
        .o_difference_total(o_difference_total),
        .o_bits_used       (o_bits_used),
        .o_last_result     (o_last_result)
    );

    `include "yuv_plane_histogram_stats_assert.svh"

    // Samples are refused while the walk emits results.
    `YPH_ASSERT_IMPL(a_no_take_on_emit, i_clk, i_rst_n, cmd.emit, o_stall, "intake during emit")
    // An emit never overwrites an untaken result.
    `YPH_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, cmd.emit, !status.out_busy, "result overwritten")
    // After an emit the result is valid.
    `YPH_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, o_valid, "emit lost")

endmodule
